FILE: src/lfpid_pkg.sv
// Shared widths, configuration types, register codes and pipeline payload types
// for the line-follow PID controller. No dependencies.
package lfpid_pkg;

  localparam int unsigned PosW      = 13;
  localparam int unsigned ErrW      = 14;
  localparam int unsigned DeltaW    = 15;
  localparam int unsigned SumW      = 24;
  localparam int unsigned GainW     = 24;
  localparam int unsigned TermInW   = 25;
  localparam int unsigned TermW     = 33;
  localparam int unsigned CorrSumW  = 35;
  localparam int unsigned CorrW     = 16;
  localparam int unsigned SpeedW    = 8;
  localparam int unsigned WheelW    = 17;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  localparam logic signed [SumW-1:0]  SumMax  = 24'sh7FFFFF;
  localparam logic signed [SumW-1:0]  SumMin  = 24'sh800000;
  localparam logic signed [CorrW-1:0] CorrMax = 16'sd32767;
  localparam logic signed [CorrW-1:0] CorrMin = -16'sd32767;

  localparam logic [GainW-1:0]  GainPropRst  = 24'd6226;
  localparam logic [GainW-1:0]  GainIntegRst = 24'd66;
  localparam logic [GainW-1:0]  GainDerivRst = 24'd45875;
  localparam logic [PosW-1:0]   TargetRst    = 13'd3500;
  localparam logic [SpeedW-1:0] BaseRst      = 8'd100;
  localparam logic [SpeedW-1:0] LimitRst     = 8'd140;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_TARGET     = 3'd3,
    REG_BASE_SPEED = 3'd4,
    REG_SPEED_LIM  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  gain_prop;
    logic [GainW-1:0]  gain_integ;
    logic [GainW-1:0]  gain_deriv;
    logic [PosW-1:0]   target_position;
    logic [SpeedW-1:0] base_speed;
    logic [SpeedW-1:0] speed_limit;
  } cfg_t;

  // Error terms captured at input transfer, before the state update.
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [DeltaW-1:0] delta;
    logic signed [SumW-1:0]   sum;
  } err_t;

endpackage

FILE: src/lfpid_cfg.sv
// Configuration register file for the line-follow PID controller.
// Depends on lfpid_pkg.
module lfpid_cfg import lfpid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GAIN_PROP:  cfg_d.gain_prop       = cfg_data_i[GainW-1:0];
        REG_GAIN_INTEG: cfg_d.gain_integ      = cfg_data_i[GainW-1:0];
        REG_GAIN_DERIV: cfg_d.gain_deriv      = cfg_data_i[GainW-1:0];
        REG_TARGET:     cfg_d.target_position = cfg_data_i[PosW-1:0];
        REG_BASE_SPEED: cfg_d.base_speed      = cfg_data_i[SpeedW-1:0];
        REG_SPEED_LIM:  cfg_d.speed_limit     = cfg_data_i[SpeedW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop       <= GainPropRst;
      cfg_q.gain_integ      <= GainIntegRst;
      cfg_q.gain_deriv      <= GainDerivRst;
      cfg_q.target_position <= TargetRst;
      cfg_q.base_speed      <= BaseRst;
      cfg_q.speed_limit     <= LimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/lfpid_front.sv
// Input stage: error, error delta, saturating error sum and the controller state.
// Depends on lfpid_pkg.
module lfpid_front import lfpid_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [PosW-1:0] line_position_i,
  input  logic [PosW-1:0] target_i,
  output err_t            stage_o
);

  logic signed [ErrW-1:0]   prev_err_q;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic signed [ErrW-1:0]   err;
  logic signed [DeltaW-1:0] delta;
  logic signed [SumW:0]     sum_ext;
  err_t                     stage_q, stage_d;

  always_comb begin
    err     = $signed({1'b0, line_position_i}) - $signed({1'b0, target_i});
    delta   = $signed({err[ErrW-1], err}) - $signed({prev_err_q[ErrW-1], prev_err_q});
    sum_ext = $signed({sum_q[SumW-1], sum_q})
            + $signed({{(SumW+1-ErrW){err[ErrW-1]}}, err});
    // Overflow shows as a mismatch of the two top bits.
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_d = sum_ext[SumW] ? SumMin : SumMax;
    end else begin
      sum_d = sum_ext[SumW-1:0];
    end
    stage_d.err   = err;
    stage_d.delta = delta;
    stage_d.sum   = sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      sum_q      <= '0;
    end else if (accept_i) begin
      prev_err_q <= err;
      sum_q      <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

FILE: src/lfpid_term.sv
// One PID term: unsigned Q8.16 gain times a signed value, truncated toward zero.
// Depends on lfpid_pkg.
module lfpid_term import lfpid_pkg::*; (
  input  logic [GainW-1:0]          gain_i,
  input  logic signed [TermInW-1:0] value_i,
  output logic signed [TermW-1:0]   term_o
);

  logic                     neg;
  logic [TermInW-1:0]       mag_full;
  logic [GainW-1:0]         mag;
  logic [2*GainW-1:0]       prod;
  logic [TermW-2:0]         shifted;

  always_comb begin
    neg      = value_i[TermInW-1];
    mag_full = neg ? TermInW'(-value_i) : TermInW'(value_i);
    mag      = mag_full[GainW-1:0];
    prod     = gain_i * mag;
    shifted  = prod[2*GainW-1:16];
    term_o   = neg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
  end

endmodule

FILE: src/lfpid_drive.sv
// One wheel: base speed plus or minus the correction, clamped magnitude and direction.
// Depends on lfpid_pkg.
module lfpid_drive import lfpid_pkg::*; (
  input  logic [SpeedW-1:0]       base_i,
  input  logic [SpeedW-1:0]       limit_i,
  input  logic signed [CorrW-1:0] corr_i,
  input  logic                    subtract_i,
  output logic [SpeedW-1:0]       pwm_o,
  output logic                    reverse_o
);

  logic signed [WheelW-1:0] base_ext, corr_ext, speed;
  logic [WheelW-1:0]        mag;

  always_comb begin
    base_ext  = $signed({{(WheelW-SpeedW){1'b0}}, base_i});
    corr_ext  = $signed({corr_i[CorrW-1], corr_i});
    speed     = subtract_i ? base_ext - corr_ext : base_ext + corr_ext;
    reverse_o = speed[WheelW-1];
    mag       = reverse_o ? WheelW'(-speed) : WheelW'(speed);
    if (mag > {{(WheelW-SpeedW){1'b0}}, limit_i}) begin
      pwm_o = limit_i;
    end else begin
      pwm_o = mag[SpeedW-1:0];
    end
  end

endmodule

FILE: src/line_follow_pid_differential_drive.sv
// Line-follow PID controller for a differential-drive robot: one line position in,
// one correction and two wheel commands out. Four register stages: error and state
// update, the three gain products, the saturated PID sum, and the wheel outputs.
// A reading can be transferred in every cycle while the output side does not stall; each
// result passes through the error stage, the gain-product registers, the sum register and
// the output registers, and leaves when out_ready_i accepts it. The error sum and last
// error are updated at input transfer, so consecutive readings need no gap.
// Each stage holds its item only while the stage after it is full and stalled.
// Configuration registers should be written only while no item is in flight.
module line_follow_pid_differential_drive import lfpid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PosW-1:0]     line_position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CorrW-1:0]    correction_o,
  output logic [SpeedW-1:0]   right_pwm_o,
  output logic                right_reverse_o,
  output logic [SpeedW-1:0]   left_pwm_o,
  output logic                left_reverse_o
);

  cfg_t cfg;
  err_t s1;

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;
  logic accept;

  logic signed [TermW-1:0]    term_p, term_i, term_d;
  logic signed [TermW-1:0]    term_p_q, term_i_q, term_d_q;
  logic signed [CorrSumW-1:0] corr_sum;
  logic signed [CorrW-1:0]    corr_d, corr_q;
  logic [SpeedW-1:0]          rpwm, lpwm;
  logic                       rrev, lrev;

  logic [CorrW-1:0]  correction_q;
  logic [SpeedW-1:0] right_pwm_q, left_pwm_q;
  logic              right_reverse_q, left_reverse_q;

  assign adv4       = !v4_q || out_ready_i;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign accept     = in_valid_i && adv1;

  lfpid_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfpid_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .line_position_i (line_position_i),
    .target_i        (cfg.target_position),
    .stage_o         (s1)
  );

  lfpid_term u_term_p (
    .gain_i  (cfg.gain_prop),
    .value_i ({{(TermInW-ErrW){s1.err[ErrW-1]}}, s1.err}),
    .term_o  (term_p)
  );

  lfpid_term u_term_i (
    .gain_i  (cfg.gain_integ),
    .value_i ({s1.sum[SumW-1], s1.sum}),
    .term_o  (term_i)
  );

  lfpid_term u_term_d (
    .gain_i  (cfg.gain_deriv),
    .value_i ({{(TermInW-DeltaW){s1.delta[DeltaW-1]}}, s1.delta}),
    .term_o  (term_d)
  );

  always_comb begin
    corr_sum = $signed({{(CorrSumW-TermW){term_p_q[TermW-1]}}, term_p_q})
             + $signed({{(CorrSumW-TermW){term_i_q[TermW-1]}}, term_i_q})
             + $signed({{(CorrSumW-TermW){term_d_q[TermW-1]}}, term_d_q});
    if (corr_sum > $signed({{(CorrSumW-CorrW){1'b0}}, CorrMax})) begin
      corr_d = CorrMax;
    end else if (corr_sum < $signed({{(CorrSumW-CorrW){1'b1}}, CorrMin})) begin
      corr_d = CorrMin;
    end else begin
      corr_d = corr_sum[CorrW-1:0];
    end
  end

  lfpid_drive u_right (
    .base_i     (cfg.base_speed),
    .limit_i    (cfg.speed_limit),
    .corr_i     (corr_q),
    .subtract_i (1'b0),
    .pwm_o      (rpwm),
    .reverse_o  (rrev)
  );

  lfpid_drive u_left (
    .base_i     (cfg.base_speed),
    .limit_i    (cfg.speed_limit),
    .corr_i     (corr_q),
    .subtract_i (1'b1),
    .pwm_o      (lpwm),
    .reverse_o  (lrev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      term_p_q <= term_p;
      term_i_q <= term_i;
      term_d_q <= term_d;
    end
    if (adv3 && v2_q) begin
      corr_q <= corr_d;
    end
    if (adv4 && v3_q) begin
      correction_q    <= corr_q;
      right_pwm_q     <= rpwm;
      right_reverse_q <= rrev;
      left_pwm_q      <= lpwm;
      left_reverse_q  <= lrev;
    end
  end

  assign out_valid_o     = v4_q;
  assign correction_o    = correction_q;
  assign right_pwm_o     = right_pwm_q;
  assign right_reverse_o = right_reverse_q;
  assign left_pwm_o      = left_pwm_q;
  assign left_reverse_o  = left_reverse_q;

endmodule

FILE: src/lfpid_checker.sv
// Port-level checks for the line-follow PID controller, bound to the top level.
// Depends on lfpid_pkg.
module lfpid_checker import lfpid_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [CorrW-1:0]    correction_o,
  input logic [SpeedW-1:0]   right_pwm_o,
  input logic                right_reverse_o,
  input logic [SpeedW-1:0]   left_pwm_o,
  input logic                left_reverse_o
);

  // A stalled result's correction and wheel PWM values must hold until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(correction_o)
      && $stable(right_pwm_o) && $stable(left_pwm_o))
    else $error("result changed while stalled");

  // Base speed is never negative, so both wheels cannot run in reverse.
  a_not_both_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(right_reverse_o && left_reverse_o))
    else $error("both wheels reversed");

  // The PID sum saturates symmetrically and never reaches the most negative code.
  a_corr_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> correction_o != 16'h8000)
    else $error("correction outside symmetric range");

  // With no correction both wheels get the same forward command.
  a_zero_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && correction_o == '0 |-> right_pwm_o == left_pwm_o
      && !right_reverse_o && !left_reverse_o)
    else $error("wheels differ with zero correction");

endmodule

bind line_follow_pid_differential_drive lfpid_checker u_lfpid_checker (.*);

FILE: verif/line_follow_pid_checker.sv
// Scoreboard for the line-follow PID controller: follows register writes, predicts
// each wheel command at input transfer and compares it at output transfer.
// Depends on lfpid_pkg.
module line_follow_pid_checker import lfpid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [PosW-1:0]     line_position_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [CorrW-1:0]    correction_i,
  input  logic [SpeedW-1:0]   right_pwm_i,
  input  logic                right_reverse_i,
  input  logic [SpeedW-1:0]   left_pwm_i,
  input  logic                left_reverse_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam int MaxReports = 200;

  typedef struct packed {
    logic [CorrW-1:0]  correction;
    logic [SpeedW-1:0] right_pwm;
    logic              right_reverse;
    logic [SpeedW-1:0] left_pwm;
    logic              left_reverse;
  } wheel_cmd_t;

  cfg_t                   regs;
  logic signed [ErrW-1:0] last_err;
  logic signed [SumW-1:0] err_acc;
  wheel_cmd_t             wheel_cmd_q [$];
  wheel_cmd_t             oldest;
  int                     errors = 0;

  // Unsigned Q8.16 gain times a signed value, truncated toward zero.
  function automatic longint gain_scale(input logic [GainW-1:0] gain, input longint value);
    longint mag;
    mag = (value < 0) ? -value : value;
    mag = (longint'(gain) * mag) >> 16;
    return (value < 0) ? -mag : mag;
  endfunction

  task automatic wheel_speed_to_cmd(input longint speed, input logic [SpeedW-1:0] limit,
                                    output logic [SpeedW-1:0] pwm, output logic rev);
    longint mag;
    mag = (speed < 0) ? -speed : speed;
    if (mag > longint'(limit)) mag = longint'(limit);
    pwm = mag[SpeedW-1:0];
    rev = (speed < 0);
  endtask

  // The terms use the error history as it stood before this reading.
  task automatic predict_wheel_cmd(input logic [PosW-1:0] pos);
    longint     err;
    longint     delta;
    longint     corr;
    longint     acc;
    wheel_cmd_t cmd;
    err   = longint'(pos) - longint'(regs.target_position);
    delta = err - longint'(last_err);
    corr  = gain_scale(regs.gain_prop, err) + gain_scale(regs.gain_integ, longint'(err_acc))
          + gain_scale(regs.gain_deriv, delta);
    if (corr > longint'(CorrMax)) corr = longint'(CorrMax);
    if (corr < longint'(CorrMin)) corr = longint'(CorrMin);
    last_err = err[ErrW-1:0];
    acc = longint'(err_acc) + err;
    if (acc > longint'(SumMax)) acc = longint'(SumMax);
    if (acc < longint'(SumMin)) acc = longint'(SumMin);
    err_acc = acc[SumW-1:0];
    cmd.correction = corr[CorrW-1:0];
    wheel_speed_to_cmd(longint'(regs.base_speed) + corr, regs.speed_limit,
                       cmd.right_pwm, cmd.right_reverse);
    wheel_speed_to_cmd(longint'(regs.base_speed) - corr, regs.speed_limit,
                       cmd.left_pwm, cmd.left_reverse);
    wheel_cmd_q.push_back(cmd);
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < MaxReports) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.gain_prop       = GainPropRst;
      regs.gain_integ      = GainIntegRst;
      regs.gain_deriv      = GainDerivRst;
      regs.target_position = TargetRst;
      regs.base_speed      = BaseRst;
      regs.speed_limit     = LimitRst;
      last_err             = '0;
      err_acc              = '0;
      wheel_cmd_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (wheel_cmd_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with no reading pending, correction %0d",
                                    $signed(correction_i)));
        end else begin
          oldest = wheel_cmd_q.pop_front();
          check_field("correction", longint'($signed(correction_i)),
                      longint'($signed(oldest.correction)));
          check_field("right_pwm", longint'(right_pwm_i), longint'(oldest.right_pwm));
          check_field("right_reverse", longint'(right_reverse_i),
                      longint'(oldest.right_reverse));
          check_field("left_pwm", longint'(left_pwm_i), longint'(oldest.left_pwm));
          check_field("left_reverse", longint'(left_reverse_i), longint'(oldest.left_reverse));
        end
      end
      if (in_valid_i && in_ready_i) predict_wheel_cmd(line_position_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_PROP:  regs.gain_prop       = cfg_data_i[GainW-1:0];
          REG_GAIN_INTEG: regs.gain_integ      = cfg_data_i[GainW-1:0];
          REG_GAIN_DERIV: regs.gain_deriv      = cfg_data_i[GainW-1:0];
          REG_TARGET:     regs.target_position = cfg_data_i[PosW-1:0];
          REG_BASE_SPEED: regs.base_speed      = cfg_data_i[SpeedW-1:0];
          REG_SPEED_LIM:  regs.speed_limit     = cfg_data_i[SpeedW-1:0];
          default: ;
        endcase
      end
    end
    pending_o    <= wheel_cmd_q.size();
    mismatches_o <= errors;
  end

endmodule

FILE: verif/line_follow_pid_differential_drive_tb.sv
// Testbench top for the line-follow PID controller: clock, reset, register writes
// and line-position stimulus with random idling on both channels.
// Depends on lfpid_pkg, line_follow_pid_differential_drive and line_follow_pid_checker.
module line_follow_pid_differential_drive_tb;
  import lfpid_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int QuietCycles = 8;
  localparam int TailCycles  = 16;

  localparam logic [CfgIdxW-1:0] SpareIdxLo = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 3'd7;
  localparam logic [GainW-1:0]   GainMax    = 24'hFFFFFF;
  localparam logic [GainW-1:0]   GainUnity  = 24'd65536;
  localparam logic [GainW-1:0]   GainWind   = 24'd2;

  typedef enum int {MIX_GENERAL, MIX_WIND_UP, MIX_WIND_DOWN} pos_mix_e;
  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx       = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [PosW-1:0]     line_position = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [CorrW-1:0]    correction;
  logic [SpeedW-1:0]   right_pwm;
  logic                right_reverse;
  logic [SpeedW-1:0]   left_pwm;
  logic                left_reverse;

  int              mismatches;
  int              pending;
  int              cycle_count = 0;
  int              burst_left  = 0;
  rx_mode_e        rx_mode     = RX_STREAM;
  int              mode_left   = 0;
  int              stall_run   = 0;
  logic [PosW-1:0] cur_target  = TargetRst;

  int unsigned corner_pos [16] = '{3500, 3500, 0, 7000, 8191, 0, 8191, 1,
                                   6999, 4095, 4096, 3499, 3501, 8190, 2, 3500};

  line_follow_pid_differential_drive dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .line_position_i (line_position),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .correction_o    (correction),
    .right_pwm_o     (right_pwm),
    .right_reverse_o (right_reverse),
    .left_pwm_o      (left_pwm),
    .left_reverse_o  (left_reverse)
  );

  line_follow_pid_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .line_position_i (line_position),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .correction_i    (correction),
    .right_pwm_i     (right_pwm),
    .right_reverse_i (right_reverse),
    .left_pwm_i      (left_pwm),
    .left_reverse_i  (left_reverse),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("line_follow_pid_differential_drive_tb NOT OK");
      $finish;
    end
  end

  // The result side switches between stall patterns at random intervals.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_STREAM: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (mode_left % 4 == 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 15);
        end
      end
    endcase
  end

  // Every task below is entered and left just after a rising edge.
  task automatic send_position(input logic [PosW-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    line_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Narrow registers sometimes get garbage above their width, which must be dropped.
  function automatic logic [CfgDataW-1:0] pad_upper_bits(input logic [CfgDataW-1:0] value,
                                                         input int unsigned width);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom());
    if ($urandom_range(0, 1) == 0) junk = '0;
    return (junk << width) | value;
  endfunction

  task automatic configure(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                           input logic [GainW-1:0] kd, input logic [PosW-1:0] target,
                           input logic [SpeedW-1:0] base, input logic [SpeedW-1:0] limit);
    wait_quiet();
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_GAIN_DERIV, kd);
    write_reg(REG_TARGET, pad_upper_bits(CfgDataW'(target), PosW));
    write_reg(REG_BASE_SPEED, pad_upper_bits(CfgDataW'(base), SpeedW));
    write_reg(REG_SPEED_LIM, pad_upper_bits(CfgDataW'(limit), SpeedW));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? SpareIdxHi : SpareIdxLo, CfgDataW'($urandom()));
    cfg_we     <= 1'b0;
    cur_target  = target;
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GainMax;
      2:       return GainW'($urandom_range(0, 255));
      5:       return GainW'($urandom());
      default: return GainW'($urandom_range(0, 131072));
    endcase
  endfunction

  function automatic logic [SpeedW-1:0] pick_speed();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return SpeedW'($urandom_range(0, 255));
  endfunction

  function automatic logic [PosW-1:0] pick_position(input pos_mix_e mix);
    int r;
    int t;
    case (mix)
      MIX_WIND_UP:   return PosW'($urandom_range(7900, 8191));
      MIX_WIND_DOWN: return PosW'($urandom_range(0, 300));
      default: begin
        r = $urandom_range(0, 99);
        if (r < 55) return PosW'($urandom_range(0, 7000));
        if (r < 75) begin
          t = int'(cur_target) + int'($urandom_range(0, 400)) - 200;
          if (t < 0) t = 0;
          if (t > 8191) t = 8191;
          return PosW'(t);
        end
        if (r < 88) return PosW'($urandom_range(0, 8191));
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return 13'd7000;
          2:       return 13'd8191;
          default: return cur_target;
        endcase
      end
    endcase
  endfunction

  task automatic run_positions(input int count, input pos_mix_e mix);
    repeat (count) send_position(pick_position(mix));
  endtask

  task automatic random_config();
    logic [PosW-1:0] target;
    case ($urandom_range(0, 4))
      0:       target = '0;
      1:       target = 13'd7000;
      2:       target = 13'd8191;
      3:       target = 13'd3500;
      default: target = PosW'($urandom_range(0, 8191));
    endcase
    configure(pick_gain(), pick_gain(), pick_gain(), target, pick_speed(), pick_speed());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: centered, extreme and out-of-range readings.
    foreach (corner_pos[i]) send_position(PosW'(corner_pos[i]));

    // Saturated correction both ways against a zero limit, then zero speed on both wheels.
    configure(GainMax, '0, '0, 13'd4096, 8'd0, 8'd0);
    send_position(13'd0);
    send_position(13'd8191);
    send_position(13'd4096);

    // Unity gain: each wheel in turn reaches zero and reverses, and the right wheel runs into the clamp.
    configure(GainUnity, '0, '0, 13'd3500, 8'd50, 8'd255);
    send_position(13'd3450);
    send_position(13'd3550);
    send_position(13'd3300);
    send_position(13'd3800);
    send_position(13'd3500);

    // Build a large positive error sum and then swing it negative. A small integral
    // gain keeps the correction clear of its own limit so the sum stays visible.
    configure('0, GainWind, '0, 13'd0, 8'd128, 8'd255);
    run_positions(100, MIX_WIND_UP);
    configure('0, GainWind, '0, 13'd8191, 8'd128, 8'd255);
    run_positions(150, MIX_WIND_DOWN);

    configure(GainMax, GainMax, GainMax, 13'd0, 8'd255, 8'd255);
    run_positions(30, MIX_GENERAL);
    configure('0, '0, '0, 13'd3500, 8'd255, 8'd128);
    run_positions(30, MIX_GENERAL);

    repeat (6) begin
      random_config();
      run_positions(60, MIX_GENERAL);
    end

    configure(GainPropRst, GainIntegRst, GainDerivRst, TargetRst, BaseRst, LimitRst);
    run_positions(60, MIX_GENERAL);

    wait_quiet();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("line_follow_pid_differential_drive_tb OK");
    end else begin
      $display("line_follow_pid_differential_drive_tb NOT OK");
    end
    $finish;
  end

endmodule
